[rtl/swrl_pkg.sv]
// Package for the sliding window rate limiter.
// Holds the history size, field widths, register indexes and the
// controller/datapath handshake structs. It depends on nothing.
package swrl_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int COUNT_W = $clog2(HISTORY_DEPTH + 1);

  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int RECENT_W = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_REQUEST_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SECONDS = 2'd1;

  localparam logic [CFG_W-1:0] RESET_REQUEST_LIMIT = 16'd30;
  localparam logic [CFG_W-1:0] RESET_WINDOW_SECONDS = 16'd60;

  typedef struct packed {
    logic start;
    logic issue_read;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic last_read;
  } ctl_status_t;

endpackage

[rtl/swrl_ctrl.sv]
// Controller state machine for the sliding window rate limiter.
// Sequences the history scan and the result hand-off; depends on swrl_pkg.
module swrl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  swrl_pkg::ctl_status_t  status,
  output swrl_pkg::ctl_cmd_t     cmd
);
  import swrl_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    READ,
    DRAIN,
    DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.start      = (state == IDLE) && in_valid;
    cmd.issue_read = (state == READ);
    cmd.commit     = (state == DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= status.empty ? DONE : READ;
          end
        end
        READ: begin
          if (status.last_read) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= DONE;
        end
        DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/swrl_datapath.sv]
// Datapath for the sliding window rate limiter: stamp memory, scan counter,
// window count and oldest-age accumulators, and result registers.
// Depends on swrl_pkg.
module swrl_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [swrl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [swrl_pkg::CFG_W-1:0]            cfg_data,
  input  logic [swrl_pkg::TIME_W-1:0]           now_seconds,
  input  swrl_pkg::ctl_cmd_t                    cmd,
  output swrl_pkg::ctl_status_t                 status,
  output logic                                  granted,
  output logic [swrl_pkg::RECENT_W-1:0]         recent_count,
  output logic [swrl_pkg::CFG_W-1:0]            wait_seconds
);
  import swrl_pkg::*;

  logic [TIME_W-1:0]  grant_stamps [HISTORY_DEPTH];

  logic [CFG_W-1:0]   request_limit;
  logic [CFG_W-1:0]   window_seconds;
  logic [COUNT_W-1:0] filled_entries;
  logic [HIST_AW-1:0] next_slot;
  logic               rd_valid;

  logic [TIME_W-1:0]  now_reg;
  logic [COUNT_W-1:0] scan_idx;
  logic [TIME_W-1:0]  rd_data;
  logic [COUNT_W-1:0] recent;
  logic [TIME_W-1:0]  oldest_age;

  logic [TIME_W-1:0]  age;
  logic [TIME_W-1:0]  window_ext;
  logic               grant;
  logic [CFG_W-1:0]   wait_value;

  assign window_ext = {{(TIME_W-CFG_W){1'b0}}, window_seconds};
  assign age        = now_reg - rd_data;
  assign grant      = {{(CFG_W-COUNT_W){1'b0}}, recent} < request_limit;

  always_comb begin
    if ((filled_entries != '0) && (oldest_age < window_ext)) begin
      wait_value = window_seconds - oldest_age[CFG_W-1:0];
    end else begin
      wait_value = '0;
    end
  end

  assign status.empty     = (filled_entries == '0);
  assign status.last_read = ((scan_idx + COUNT_W'(1)) == filled_entries);

  always_ff @(posedge clk) begin
    if (rst) begin
      request_limit  <= RESET_REQUEST_LIMIT;
      window_seconds <= RESET_WINDOW_SECONDS;
      filled_entries <= '0;
      next_slot      <= '0;
      rd_valid       <= 1'b0;
    end else begin
      rd_valid <= cmd.issue_read;
      if (cfg_write) begin
        if (cfg_index == REG_REQUEST_LIMIT) begin
          request_limit <= cfg_data;
        end else if (cfg_index == REG_WINDOW_SECONDS) begin
          window_seconds <= cfg_data;
        end
      end
      if (cmd.commit && grant) begin
        if (next_slot == HIST_AW'(HISTORY_DEPTH - 1)) begin
          next_slot <= '0;
        end else begin
          next_slot <= next_slot + HIST_AW'(1);
        end
        if (filled_entries != COUNT_W'(HISTORY_DEPTH)) begin
          filled_entries <= filled_entries + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      now_reg    <= now_seconds;
      scan_idx   <= '0;
      recent     <= '0;
      oldest_age <= '0;
    end else begin
      if (cmd.issue_read) begin
        scan_idx <= scan_idx + COUNT_W'(1);
      end
      if (rd_valid) begin
        if (age < window_ext) begin
          recent <= recent + COUNT_W'(1);
        end
        if (age > oldest_age) begin
          oldest_age <= age;
        end
      end
    end
    if (cmd.commit) begin
      granted      <= grant;
      recent_count <= RECENT_W'(recent);
      wait_seconds <= wait_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue_read) begin
      rd_data <= grant_stamps[scan_idx[HIST_AW-1:0]];
    end
    if (cmd.commit && grant) begin
      grant_stamps[next_slot] <= now_reg;
    end
  end

endmodule

[rtl/sliding_window_rate_limiter_unit.sv]
// Sliding window rate limiter top level: controller plus datapath.
// A request is accepted in IDLE, then the controller scans every held stamp
// (READ), lets the last read settle (DRAIN) and commits the result (DONE); one
// item is in work at a time, so a new request waits until the scan ends.
// Synchronous reset clears the history count and ring pointer and restores
// the limit to 30 and the window to 60 seconds; the memory itself is not cleared.
module sliding_window_rate_limiter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [swrl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [swrl_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [swrl_pkg::TIME_W-1:0]       now_seconds,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              granted,
  output logic [swrl_pkg::RECENT_W-1:0]     recent_count,
  output logic [swrl_pkg::CFG_W-1:0]        wait_seconds
);
  import swrl_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  swrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  swrl_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .now_seconds  (now_seconds),
    .cmd          (cmd),
    .status       (status),
    .granted      (granted),
    .recent_count (recent_count),
    .wait_seconds (wait_seconds)
  );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for sliding_window_rate_limiter_unit.
// It predicts each grant verdict from its own model of the stamp ring and checks each result
// in order, under random idling on both channels. It depends on swrl_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swrl_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 900;

  typedef struct packed {
    logic                granted;
    logic [RECENT_W-1:0] recent;
    logic [CFG_W-1:0]    wait_secs;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [TIME_W-1:0]      now_seconds = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   granted;
  logic [RECENT_W-1:0]    recent_count;
  logic [CFG_W-1:0]       wait_seconds;

  logic [TIME_W-1:0] request_times[$];
  verdict_t          expected_verdicts[$];

  logic [TIME_W-1:0] stamp_ring[HISTORY_DEPTH];
  int unsigned       stamps_held;
  int unsigned       ring_head;
  logic [CFG_W-1:0]  grant_cap;
  logic [CFG_W-1:0]  window_len;

  int       mismatches = 0;
  int       idle_cycles = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       stall_draw;
  bit       quiet = 1'b0;
  verdict_t seen;
  verdict_t want;

  sliding_window_rate_limiter_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .now_seconds(now_seconds),
    .out_valid(out_valid), .out_ready(out_ready),
    .granted(granted), .recent_count(recent_count), .wait_seconds(wait_seconds)
  );

  always #10 clk = ~clk;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic judge_request(input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] oldest_age;
    int unsigned       recent;
    verdict_t          v;
    recent = 0;
    oldest_age = '0;
    for (int i = 0; i < stamps_held; i++) begin
      age = now - stamp_ring[i];
      if (age < {16'd0, window_len}) recent++;
      if (age > oldest_age) oldest_age = age;
    end
    v.granted = (recent < grant_cap);
    v.recent = recent[RECENT_W-1:0];
    if (stamps_held > 0 && oldest_age < {16'd0, window_len}) begin
      v.wait_secs = window_len - oldest_age[CFG_W-1:0];
    end else begin
      v.wait_secs = '0;
    end
    if (v.granted) begin
      stamp_ring[ring_head] = now;
      ring_head = (ring_head + 1) % HISTORY_DEPTH;
      if (stamps_held < HISTORY_DEPTH) stamps_held++;
    end
    expected_verdicts.push_back(v);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_REQUEST_LIMIT) grant_cap = val;
    else if (idx == REG_WINDOW_SECONDS) window_len = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // The check runs after the edge has settled, so an item popped at this edge is seen.
  task automatic wait_quiet();
    while (request_times.size() != 0 || in_valid || expected_verdicts.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic queue_requests(input int count, input logic [TIME_W-1:0] base,
                                input logic [TIME_W-1:0] step_max);
    logic [TIME_W-1:0] t;
    t = base;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0: t = $urandom();
        1: t = t - $urandom_range(0, step_max);
        default: t = t + $urandom_range(0, step_max);
      endcase
      request_times.push_back(t);
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd30;
      3: return 16'd63;
      4: return 16'd64;
      5: return 16'd65;
      6: return 16'hFFFF;
      7: return CFG_W'($urandom());
      default: return CFG_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_window();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd60;
      3: return 16'hFFFF;
      4: return CFG_W'($urandom());
      default: return CFG_W'($urandom_range(2, 300));
    endcase
  endfunction

  // Driver: presents one request item at a time from request_times.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) judge_request(now_seconds);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (request_times.size() != 0) begin
          in_valid <= 1'b1;
          now_seconds <= request_times.pop_front();
          gap_left <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes each result item and checks it against the oldest verdict.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      seen = '{granted: granted, recent: recent_count, wait_secs: wait_seconds};
      if (expected_verdicts.size() == 0) begin
        report($sformatf("unexpected result %p", seen));
      end else begin
        want = expected_verdicts.pop_front();
        if (seen.granted !== want.granted)
          report($sformatf("granted %b, expected %b", seen.granted, want.granted));
        if (seen.recent !== want.recent)
          report($sformatf("recent_count %0d, expected %0d", seen.recent, want.recent));
        if (seen.wait_secs !== want.wait_secs)
          report($sformatf("wait_seconds %0d, expected %0d", seen.wait_secs, want.wait_secs));
      end
      stall_draw = draw_gap();
      stall_left <= stall_draw;
      out_ready <= (stall_draw == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                count;
    int                random_sent;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] step_max;

    grant_cap = RESET_REQUEST_LIMIT;
    window_len = RESET_WINDOW_SECONDS;
    stamps_held = 0;
    ring_head = 0;
    for (int i = 0; i < HISTORY_DEPTH; i++) stamp_ring[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, empty history, window edge and time wrap.
    request_times = '{32'd0, 32'd0, 32'd59, 32'd60, 32'hFFFF_FFFF, 32'd5,
                      32'h7FFF_FFFF, 32'h8000_0000};
    wait_quiet();
    write_reg(REG_REQUEST_LIMIT, 16'd0);
    request_times = '{32'd100, 32'd101};
    wait_quiet();
    write_reg(REG_REQUEST_LIMIT, 16'hFFFF);
    write_reg(REG_WINDOW_SECONDS, 16'd0);
    request_times = '{32'd200, 32'd200};
    wait_quiet();
    write_reg(REG_REQUEST_LIMIT, 16'd2);
    write_reg(REG_WINDOW_SECONDS, 16'hFFFF);
    request_times = '{32'd300, 32'd300, 32'd300, 32'd65834, 32'hFFFF_0000};
    wait_quiet();
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0000);
    request_times = '{32'd70000, 32'd70000};
    wait_quiet();
    write_reg(REG_REQUEST_LIMIT, 16'd1);
    write_reg(REG_WINDOW_SECONDS, 16'd1);
    request_times = '{32'd1, 32'd1, 32'd2};
    wait_quiet();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      @(posedge clk);
      quiet = ($urandom_range(0, 3) == 0);
      write_reg(REG_REQUEST_LIMIT, pick_limit());
      write_reg(REG_WINDOW_SECONDS, pick_window());
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_INDEX_W'($urandom_range(2, 3)), CFG_W'($urandom()));
      count = $urandom_range(40, 100);
      base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000)
                                         : $urandom();
      case ($urandom_range(0, 3))
        0: step_max = 2;
        1: step_max = window_len / 16 + 1;
        2: step_max = window_len / 2 + 1;
        default: step_max = 2 * window_len + 1;
      endcase
      queue_requests(count, base, step_max);
      wait_quiet();
      random_sent += count;
    end

    quiet = 1'b0;
    repeat (100) @(posedge clk);
    if (expected_verdicts.size() != 0)
      report($sformatf("%0d results never arrived", expected_verdicts.size()));
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
